// File: hw/rtl/ipse_pkg.sv
`timescale 1ns / 1ps

package ipse_pkg;

    localparam int TIME_BITS_DEF = 48;

    localparam int MINUTES_W  = 16;
    localparam int MS_W       = 32;
    localparam int CFG_DATA_W = 32;
    localparam int CFG_IDX_W  = 3;
    localparam int POWER_W    = 3;

    localparam logic [MS_W-1:0] MS_PER_MINUTE = 32'd60000;

    localparam logic [CFG_IDX_W-1:0] REG_LOCK_MINUTES      = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SLEEP_MINUTES     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_HYBRID_MINUTES    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_HIBERNATE_MINUTES = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_POWEROFF_MINUTES  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_SYNC_INTERVAL_MS  = 3'd5;

    localparam logic [MINUTES_W-1:0] LOCK_MINUTES_RST      = 16'd5;
    localparam logic [MINUTES_W-1:0] SLEEP_MINUTES_RST     = 16'd15;
    localparam logic [MINUTES_W-1:0] HYBRID_MINUTES_RST    = 16'd30;
    localparam logic [MINUTES_W-1:0] HIBERNATE_MINUTES_RST = 16'd60;
    localparam logic [MINUTES_W-1:0] POWEROFF_MINUTES_RST  = 16'd120;
    localparam logic [MS_W-1:0]      SYNC_INTERVAL_MS_RST  = 32'd7200000;

    typedef enum logic [POWER_W-1:0] {
        PWR_NONE      = 3'd0,
        PWR_SLEEP     = 3'd1,
        PWR_HYBRID    = 3'd2,
        PWR_HIBERNATE = 3'd3,
        PWR_OFF       = 3'd4
    } power_t;

    // Thresholds held in milliseconds: minutes times 60000 fits in 32 bits
    typedef struct packed {
        logic [MS_W-1:0] lock_ms;
        logic [MS_W-1:0] sleep_ms;
        logic [MS_W-1:0] hybrid_ms;
        logic [MS_W-1:0] hibernate_ms;
        logic [MS_W-1:0] poweroff_ms;
        logic [MS_W-1:0] sync_interval_ms;
    } ipse_cfg_t;

    function automatic logic [MS_W-1:0] minutes_to_ms(input logic [MINUTES_W-1:0] minutes);
        logic [MS_W-1:0] wide;
        wide = {{(MS_W-MINUTES_W){1'b0}}, minutes};
        return wide * MS_PER_MINUTE;
    endfunction

endpackage

// File: hw/rtl/ipse_if.sv
`timescale 1ns / 1ps

interface ipse_poll_if #(
    parameter int TIME_BITS = ipse_pkg::TIME_BITS_DEF
);
    logic                 valid;
    logic                 ready;
    logic [TIME_BITS-1:0] now_ms;
    logic [TIME_BITS-1:0] last_activity_ms;
    logic                 display_locked;

    modport source (
        output valid,
        output now_ms,
        output last_activity_ms,
        output display_locked,
        input  ready
    );

    modport sink (
        input  valid,
        input  now_ms,
        input  last_activity_ms,
        input  display_locked,
        output ready
    );
endinterface

interface ipse_result_if;
    logic       valid;
    logic       ready;
    logic       sync_pulse;
    logic       lock_request;
    logic [2:0] power_request;

    modport source (
        output valid,
        output sync_pulse,
        output lock_request,
        output power_request,
        input  ready
    );

    modport sink (
        input  valid,
        input  sync_pulse,
        input  lock_request,
        input  power_request,
        output ready
    );
endinterface

// File: hw/rtl/ipse_cfg_regs.sv
`timescale 1ns / 1ps

module ipse_cfg_regs (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic [ipse_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [ipse_pkg::CFG_DATA_W-1:0] cfg_data,
    output ipse_pkg::ipse_cfg_t            cfg
);
    import ipse_pkg::*;

    ipse_cfg_t        cfg_reg;
    ipse_cfg_t        cfg_next;
    logic [MS_W-1:0]  data_ms;

    assign data_ms = minutes_to_ms(cfg_data[MINUTES_W-1:0]);

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            unique case (cfg_index)
                REG_LOCK_MINUTES:      cfg_next.lock_ms          = data_ms;
                REG_SLEEP_MINUTES:     cfg_next.sleep_ms         = data_ms;
                REG_HYBRID_MINUTES:    cfg_next.hybrid_ms        = data_ms;
                REG_HIBERNATE_MINUTES: cfg_next.hibernate_ms     = data_ms;
                REG_POWEROFF_MINUTES:  cfg_next.poweroff_ms      = data_ms;
                REG_SYNC_INTERVAL_MS:  cfg_next.sync_interval_ms = cfg_data[MS_W-1:0];
                default:               cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.lock_ms          <= minutes_to_ms(LOCK_MINUTES_RST);
            cfg_reg.sleep_ms         <= minutes_to_ms(SLEEP_MINUTES_RST);
            cfg_reg.hybrid_ms        <= minutes_to_ms(HYBRID_MINUTES_RST);
            cfg_reg.hibernate_ms     <= minutes_to_ms(HIBERNATE_MINUTES_RST);
            cfg_reg.poweroff_ms      <= minutes_to_ms(POWEROFF_MINUTES_RST);
            cfg_reg.sync_interval_ms <= SYNC_INTERVAL_MS_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

// File: hw/rtl/ipse_core.sv
`timescale 1ns / 1ps

module ipse_core #(
    parameter int TIME_BITS = ipse_pkg::TIME_BITS_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  ipse_pkg::ipse_cfg_t cfg,
    ipse_poll_if.sink           poll,
    ipse_result_if.source       result
);
    import ipse_pkg::*;

    logic                 in_valid_reg;
    logic [TIME_BITS-1:0] now_reg;
    logic [TIME_BITS-1:0] last_reg;
    logic                 locked_reg;

    logic [TIME_BITS-1:0] sync_base_reg;
    logic [TIME_BITS-1:0] sync_base_next;
    logic                 base_captured_reg;
    logic                 base_captured_next;

    logic                 out_valid_reg;
    logic                 pulse_reg;
    logic                 lock_req_reg;
    power_t               power_reg;

    logic                 advance;
    logic                 in_take;
    logic [TIME_BITS-1:0] since_sync;
    logic [TIME_BITS-1:0] idle_ms;
    logic                 pulse;
    logic                 lock_req;
    power_t               power;

    assign advance = in_valid_reg && (!out_valid_reg || result.ready);
    assign in_take = poll.valid && poll.ready;
    assign poll.ready = !in_valid_reg || advance;

    assign since_sync = now_reg - sync_base_reg;
    assign idle_ms    = now_reg - last_reg;
    assign pulse      = base_captured_reg &&
                        (since_sync >= TIME_BITS'(cfg.sync_interval_ms));
    assign lock_req   = !locked_reg && (idle_ms >= TIME_BITS'(cfg.lock_ms));

    always_comb
    begin
        priority if (idle_ms >= TIME_BITS'(cfg.poweroff_ms))
            power = PWR_OFF;
        else if (idle_ms >= TIME_BITS'(cfg.hibernate_ms))
            power = PWR_HIBERNATE;
        else if (idle_ms >= TIME_BITS'(cfg.hybrid_ms))
            power = PWR_HYBRID;
        else if (idle_ms >= TIME_BITS'(cfg.sleep_ms))
            power = PWR_SLEEP;
        else
            power = PWR_NONE;
    end

    always_comb
    begin
        sync_base_next     = sync_base_reg;
        base_captured_next = base_captured_reg;
        if (advance && (!base_captured_reg || pulse))
        begin
            sync_base_next     = now_reg;
            base_captured_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg      <= 1'b0;
            out_valid_reg     <= 1'b0;
            sync_base_reg     <= '0;
            base_captured_reg <= 1'b0;
        end
        else
        begin
            sync_base_reg     <= sync_base_next;
            base_captured_reg <= base_captured_next;
            if (poll.ready)
                in_valid_reg <= poll.valid;
            if (advance)
                out_valid_reg <= 1'b1;
            else if (result.ready)
                out_valid_reg <= 1'b0;
        end
    end

    // Hold payload words while stalled
    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            now_reg    <= poll.now_ms;
            last_reg   <= poll.last_activity_ms;
            locked_reg <= poll.display_locked;
        end
        if (advance)
        begin
            pulse_reg    <= pulse;
            lock_req_reg <= lock_req;
            power_reg    <= power;
        end
    end

    assign result.valid         = out_valid_reg;
    assign result.sync_pulse    = pulse_reg;
    assign result.lock_request  = lock_req_reg;
    assign result.power_request = power_reg;

endmodule

// File: hw/rtl/idle_power_state_escalator.sv
`timescale 1ns / 1ps

// Idle power state escalator.
// poll (valid/ready sink) takes one word per poll: now_ms, last_activity_ms
// and display_locked. result (valid/ready source) gives one word per poll:
// sync_pulse, lock_request and power_request (0 none .. 4 power off).
// Thresholds are written on the cfg_we/cfg_index/cfg_data port in minutes
// (indexes 0..4) and the sync interval in ms (index 5); other indexes are
// ignored. Write them only while no poll is in flight.
// A poll is taken into the input register, then its result word into the result
// register, where it is valid. One poll per cycle is taken back to back while result is
// not stalled, set by the single subtract-and-compare stage between the registers.
// The first poll after reset only loads the sync base and never pulses.
// When result is stalled, the result register holds its word and the input
// register takes one more poll, after which poll.ready drops.
// Reset restores the default thresholds and clears both pipeline stages.
module idle_power_state_escalator #(
    parameter int TIME_BITS = ipse_pkg::TIME_BITS_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    ipse_poll_if.sink                      poll,
    ipse_result_if.source                  result,
    input  logic                           cfg_we,
    input  logic [ipse_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [ipse_pkg::CFG_DATA_W-1:0] cfg_data
);
    import ipse_pkg::*;

    ipse_cfg_t cfg;

    ipse_cfg_regs u_cfg_regs (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    ipse_core #(
        .TIME_BITS (TIME_BITS)
    ) u_core (
        .clk    (clk),
        .rst_n  (rst_n),
        .cfg    (cfg),
        .poll   (poll),
        .result (result)
    );

endmodule

// File: bench/ipse_checker.sv
`timescale 1ns / 1ps

module ipse_checker
    import ipse_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    ipse_poll_if                  poll,
    ipse_result_if                result,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    output int                    mismatches,
    output int                    outstanding
);

    localparam int TIME_W = TIME_BITS_DEF;

    typedef logic [TIME_W-1:0] uptime_t;

    typedef struct packed {
        logic   sync_pulse;
        logic   lock_request;
        power_t power_request;
    } poll_outcome_t;

    logic [MINUTES_W-1:0] lock_min;
    logic [MINUTES_W-1:0] sleep_min;
    logic [MINUTES_W-1:0] hybrid_min;
    logic [MINUTES_W-1:0] hibernate_min;
    logic [MINUTES_W-1:0] poweroff_min;
    logic [MS_W-1:0]      sync_interval;
    uptime_t              sync_base;
    logic                 base_captured;
    poll_outcome_t        pending_outcomes[$];
    int                   error_count;
    int                   words_seen;

    assign mismatches = error_count;

    function automatic poll_outcome_t poll_outcome(input uptime_t now_v, input uptime_t last_v,
                                                   input logic locked);
        poll_outcome_t verdict;
        uptime_t       idle_ms;
        uptime_t       idle_min;
        verdict.sync_pulse = 1'b0;
        if (!base_captured) begin
            sync_base     = now_v;
            base_captured = 1'b1;
        end
        else if (uptime_t'(now_v - sync_base) >= sync_interval) begin
            verdict.sync_pulse = 1'b1;
            sync_base          = now_v;
        end
        idle_ms  = now_v - last_v;
        idle_min = idle_ms / MS_PER_MINUTE;
        verdict.lock_request = !locked && (idle_min >= lock_min);
        if (idle_min >= poweroff_min)
            verdict.power_request = PWR_OFF;
        else if (idle_min >= hibernate_min)
            verdict.power_request = PWR_HIBERNATE;
        else if (idle_min >= hybrid_min)
            verdict.power_request = PWR_HYBRID;
        else if (idle_min >= sleep_min)
            verdict.power_request = PWR_SLEEP;
        else
            verdict.power_request = PWR_NONE;
        return verdict;
    endfunction

    task automatic flag_field(input string field, input logic [2:0] want, input logic [2:0] got);
        if (error_count < 10)
            $display("mismatch on %s in result word %0d: expected %0d, got %0d",
                     field, words_seen, want, got);
        error_count++;
    endtask

    always @(posedge clk or negedge rst_n) begin
        poll_outcome_t seen;
        poll_outcome_t want;
        if (!rst_n) begin
            lock_min      = LOCK_MINUTES_RST;
            sleep_min     = SLEEP_MINUTES_RST;
            hybrid_min    = HYBRID_MINUTES_RST;
            hibernate_min = HIBERNATE_MINUTES_RST;
            poweroff_min  = POWEROFF_MINUTES_RST;
            sync_interval = SYNC_INTERVAL_MS_RST;
            sync_base     = '0;
            base_captured = 1'b0;
            pending_outcomes.delete();
            error_count   = 0;
            words_seen    = 0;
            outstanding   <= 0;
        end
        else begin
            if (cfg_we) begin
                case (cfg_index)
                    REG_LOCK_MINUTES:      lock_min      = cfg_data[MINUTES_W-1:0];
                    REG_SLEEP_MINUTES:     sleep_min     = cfg_data[MINUTES_W-1:0];
                    REG_HYBRID_MINUTES:    hybrid_min    = cfg_data[MINUTES_W-1:0];
                    REG_HIBERNATE_MINUTES: hibernate_min = cfg_data[MINUTES_W-1:0];
                    REG_POWEROFF_MINUTES:  poweroff_min  = cfg_data[MINUTES_W-1:0];
                    REG_SYNC_INTERVAL_MS:  sync_interval = cfg_data[MS_W-1:0];
                    default: ;
                endcase
            end
            if (poll.valid && poll.ready)
                pending_outcomes.push_back(poll_outcome(poll.now_ms, poll.last_activity_ms,
                                                        poll.display_locked));
            if (result.valid && result.ready) begin
                seen.sync_pulse    = result.sync_pulse;
                seen.lock_request  = result.lock_request;
                seen.power_request = power_t'(result.power_request);
                if (pending_outcomes.size() == 0) begin
                    if (error_count < 10)
                        $display("result word %0d with no poll pending: sync %0b lock %0b power %0d",
                                 words_seen, seen.sync_pulse, seen.lock_request,
                                 seen.power_request);
                    error_count++;
                end
                else begin
                    want = pending_outcomes.pop_front();
                    if (seen.sync_pulse !== want.sync_pulse)
                        flag_field("sync_pulse", want.sync_pulse, seen.sync_pulse);
                    if (seen.lock_request !== want.lock_request)
                        flag_field("lock_request", want.lock_request, seen.lock_request);
                    if (seen.power_request !== want.power_request)
                        flag_field("power_request", want.power_request, seen.power_request);
                end
                words_seen++;
            end
            outstanding <= pending_outcomes.size();
        end
    end

endmodule

// File: bench/idle_power_state_escalator_tb.sv
`timescale 1ns / 1ps

module idle_power_state_escalator_tb;
    import ipse_pkg::*;

    localparam int TIME_W       = TIME_BITS_DEF;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int DRAIN_CYCLES = 8;
    localparam int HOLD_CYCLES  = 120;
    localparam int PHASE_POLLS  = 285;

    localparam logic [CFG_IDX_W-1:0] REG_SPARE_6 = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_7 = 3'd7;

    typedef logic [TIME_W-1:0] uptime_t;

    localparam uptime_t UPTIME_MAX = '1;

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;
    int                    mismatches;
    int                    outstanding;
    int unsigned           cycle_count = 0;
    int                    send_idle_pct = 0;
    int                    recv_idle_pct = 0;
    logic                  hold_results = 1'b0;
    logic [MS_W-1:0]       cur_interval;
    int                    max_minutes;
    uptime_t               clock_ms;

    ipse_poll_if #(.TIME_BITS(TIME_W)) poll_ch ();
    ipse_result_if result_ch ();

    idle_power_state_escalator #(.TIME_BITS(TIME_W)) uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .poll      (poll_ch),
        .result    (result_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    ipse_checker chk (
        .clk         (clk),
        .rst_n       (rst_n),
        .poll        (poll_ch),
        .result      (result_ch),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .mismatches  (mismatches),
        .outstanding (outstanding)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
    end

    initial
    begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("status: fail");
        $finish;
    end

    initial
    begin
        result_ch.ready = 1'b0;
        forever
        begin
            @(posedge clk);
            result_ch.ready <= !hold_results && ($urandom_range(99) >= recv_idle_pct);
        end
    end

    task automatic send_poll(input uptime_t now_v, input uptime_t last_v, input logic locked);
        while ($urandom_range(99) < send_idle_pct)
        begin
            poll_ch.valid <= 1'b0;
            @(posedge clk);
        end
        poll_ch.valid            <= 1'b1;
        poll_ch.now_ms           <= now_v;
        poll_ch.last_activity_ms <= last_v;
        poll_ch.display_locked   <= locked;
        do @(posedge clk); while (!poll_ch.ready);
    endtask

    task automatic poll_idle(input uptime_t now_v, input int idle_min_count, input logic locked);
        send_poll(now_v, now_v - uptime_t'(idle_min_count) * MS_PER_MINUTE, locked);
    endtask

    task automatic quiesce();
        poll_ch.valid <= 1'b0;
        do @(posedge clk); while (outstanding != 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic load_config(input logic [MINUTES_W-1:0] lock_m, input logic [MINUTES_W-1:0] sleep_m,
                               input logic [MINUTES_W-1:0] hybrid_m,
                               input logic [MINUTES_W-1:0] hibernate_m,
                               input logic [MINUTES_W-1:0] poweroff_m,
                               input logic [MS_W-1:0] interval);
        int limits[5] = '{lock_m, sleep_m, hybrid_m, hibernate_m, poweroff_m};
        cfg_we    <= 1'b1;
        cfg_index <= REG_LOCK_MINUTES;
        cfg_data  <= {16'($urandom()), lock_m};
        @(posedge clk);
        cfg_index <= REG_SLEEP_MINUTES;
        cfg_data  <= {16'($urandom()), sleep_m};
        @(posedge clk);
        cfg_index <= REG_HYBRID_MINUTES;
        cfg_data  <= {16'($urandom()), hybrid_m};
        @(posedge clk);
        cfg_index <= REG_HIBERNATE_MINUTES;
        cfg_data  <= {16'($urandom()), hibernate_m};
        @(posedge clk);
        cfg_index <= REG_POWEROFF_MINUTES;
        cfg_data  <= {16'($urandom()), poweroff_m};
        @(posedge clk);
        cfg_index <= REG_SYNC_INTERVAL_MS;
        cfg_data  <= interval;
        @(posedge clk);
        // stray write to an unmapped index: must change nothing
        cfg_index <= $urandom_range(1) ? REG_SPARE_6 : REG_SPARE_7;
        cfg_data  <= $urandom();
        @(posedge clk);
        cfg_we       <= 1'b0;
        cur_interval = interval;
        max_minutes  = 0;
        foreach (limits[i])
            if (limits[i] > max_minutes)
                max_minutes = limits[i];
    endtask

    initial
    begin
        uptime_t              t;
        uptime_t              now_v;
        uptime_t              last_v;
        uptime_t              idle_ms;
        logic [MINUTES_W-1:0] lim[5];
        int                   kind;

        rst_n                    = 1'b0;
        cfg_we                   = 1'b0;
        cfg_index                = REG_LOCK_MINUTES;
        cfg_data                 = '0;
        poll_ch.valid            = 1'b0;
        poll_ch.now_ms           = '0;
        poll_ch.last_activity_ms = '0;
        poll_ch.display_locked   = 1'b0;
        cur_interval             = SYNC_INTERVAL_MS_RST;
        max_minutes              = POWEROFF_MINUTES_RST;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset thresholds: base capture, exact boundaries, future activity, wrap
        t = 48'd1000000;
        poll_idle(t, 0, 1'b0);
        poll_idle(t + 48'd7199999, 5, 1'b0);
        poll_idle(t + 48'd7200000, 15, 1'b1);
        t = t + 48'd7200001;
        poll_idle(t, 30, 1'b0);
        poll_idle(t, 60, 1'b0);
        poll_idle(t, 120, 1'b0);
        send_poll(t, t - uptime_t'(120) * MS_PER_MINUTE + 48'd1, 1'b0);
        send_poll(t, t + 48'd1, 1'b0);
        send_poll(UPTIME_MAX, '0, 1'b0);
        send_poll('0, UPTIME_MAX, 1'b0);
        send_poll('0, '0, 1'b1);

        // zero thresholds and zero interval
        quiesce();
        load_config('0, '0, '0, '0, '0, '0);
        poll_idle(48'd5, 0, 1'b0);
        poll_idle(48'd5, 0, 1'b1);
        poll_idle(UPTIME_MAX, 0, 1'b1);

        // everything at its maximum
        quiesce();
        load_config('1, '1, '1, '1, '1, '1);
        t = 48'h0000_FFFF_FFFE;
        poll_idle(t, 65535, 1'b0);
        t = 48'h0001_FFFF_FFFC;
        send_poll(t, t - uptime_t'(65535) * MS_PER_MINUTE + 48'd1, 1'b0);
        send_poll(t, t + 48'd1, 1'b1);

        // thresholds out of order
        quiesce();
        load_config(16'd10, 16'd100, 16'd50, 16'd20, 16'd200, 32'd1000);
        t = 48'h0002_0000_0000;
        poll_idle(t, 25, 1'b0);
        poll_idle(t, 55, 1'b1);
        poll_idle(t, 15, 1'b0);
        poll_idle(t, 250, 1'b0);
        poll_idle(t, 5, 1'b0);

        clock_ms = uptime_t'({$urandom(), $urandom()});
        for (int ph = 0; ph < 6; ph++)
        begin
            send_idle_pct = (ph < 2) ? 27 : (ph < 4) ? 65 : 0;
            recv_idle_pct <= (ph < 2) ? 65 : (ph < 4) ? 27 : 0;
            quiesce();
            if ($urandom_range(3) == 0)
            begin
                foreach (lim[i])
                    lim[i] = MINUTES_W'($urandom_range(0, 200));
            end
            else
            begin
                lim[0] = MINUTES_W'($urandom_range(0, 60));
                lim[1] = MINUTES_W'($urandom_range(0, 20));
                for (int i = 2; i < 5; i++)
                    lim[i] = lim[i-1] + MINUTES_W'($urandom_range(0, 40));
            end
            load_config(lim[0], lim[1], lim[2], lim[3], lim[4],
                        ($urandom_range(4) == 0) ? 32'd1 : $urandom_range(1000, 900000));
            for (int n = 0; n < PHASE_POLLS; n++)
            begin
                if (ph == 5 && n == 40)
                begin
                    // hold result back so the poll side backs up
                    fork
                        begin
                            hold_results <= 1'b1;
                            repeat (HOLD_CYCLES) @(posedge clk);
                            hold_results <= 1'b0;
                        end
                    join_none
                end
                kind = $urandom_range(99);
                if (kind < 10)
                begin
                    now_v  = uptime_t'({$urandom(), $urandom()});
                    last_v = uptime_t'({$urandom(), $urandom()});
                end
                else
                begin
                    if (kind < 13)
                        clock_ms = uptime_t'({$urandom(), $urandom()});
                    else
                        clock_ms = clock_ms + $urandom_range(0, cur_interval + cur_interval / 2);
                    now_v = clock_ms;
                    if (kind < 18)
                        last_v = now_v + $urandom_range(1, 1000000);
                    else
                    begin
                        idle_ms = uptime_t'($urandom_range(0, max_minutes + 5)) * MS_PER_MINUTE
                                  + $urandom_range(0, 59999);
                        last_v  = now_v - idle_ms;
                    end
                end
                send_poll(now_v, last_v, 1'($urandom_range(1)));
            end
        end

        quiesce();
        if (mismatches == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
